// ===== rtl/core/wind_profile_interpolator_core_macros.svh =====
// Assertion helpers shared by the wind profile interpolator RTL.
// Both macros expect a clock named clk and an active-low reset named rst_n.
`ifndef WIND_PROFILE_INTERPOLATOR_CORE_MACROS_SVH
`define WIND_PROFILE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define WPI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wpi_pkg.sv =====
package wpi_pkg;

  localparam int MAX_LAYERS = 8;
  localparam int LAYER_AW   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);

  // The fraction t is unsigned Q1.16, so it spans 0..65536.
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(T_W);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] altitude;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic signed [31:0] vel_z_in;
  } wpi_in_t;

  typedef struct packed {
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] vel_z_out;
  } wpi_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vel_t;

  typedef struct packed {
    logic signed [31:0] altitude;
    vel_t               vel;
  } layer_t;

  typedef struct packed {
    logic                wr_en;
    logic [LAYER_AW-1:0] wr_addr;
    layer_t              wr_data;
    logic [LAYER_AW-1:0] rd_addr;
  } ram_req_t;

endpackage

// ===== rtl/core/wpi_layer_ram.sv =====
module wpi_layer_ram
  import wpi_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output layer_t   rd_data
);

  // One write port, one read port, registered read data. A read of the entry
  // being written in the same cycle returns the old contents.
  layer_t mem [MAX_LAYERS];
  layer_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/wpi_frac_div.sv =====
module wpi_frac_div
  import wpi_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [31:0]    dividend,
  input  logic [31:0]    divisor,
  output logic           done,
  output logic [T_W-1:0] quot
);

  // Restoring division of (dividend << 16) by divisor, one quotient bit per
  // cycle. The dividend never exceeds the divisor, so 17 bits suffice.
  logic                 active_r, active_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [32:0]          rem_r, rem_nxt;
  logic [31:0]          den_r, den_nxt;
  logic [T_W-1:0]       quot_r, quot_nxt;
  logic                 ge;
  logic [32:0]          rem_sub;

  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    quot_nxt   = quot_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      rem_nxt    = {1'b0, dividend};
      den_nxt    = divisor;
      quot_nxt   = '0;
    end else if (active_r) begin
      rem_nxt  = {rem_sub[31:0], 1'b0};
      quot_nxt = {quot_r[T_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(T_W - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/core/wpi_lerp_unit.sv =====
module wpi_lerp_unit
  import wpi_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  vel_t           lo,
  input  vel_t           hi,
  input  logic [T_W-1:0] t,
  output logic           done,
  output vel_t           res
);

  // One multiplier shared by the three components. The product of one
  // component is registered while the previous one is shifted and added.
  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic [T_W-1:0]        t_r;
  logic signed [50:0]    prod_r;
  logic signed [31:0]    lo_pipe_r;
  vel_t                  res_r;
  logic signed [31:0]    sel_lo, sel_hi;
  logic signed [32:0]    diff;
  logic signed [50:0]    prod_nxt;
  logic signed [50:0]    prod_sh;
  logic signed [33:0]    sum;

  always_comb begin
    unique case (cnt_r)
      2'd0:    begin sel_lo = lo.x; sel_hi = hi.x; end
      2'd1:    begin sel_lo = lo.y; sel_hi = hi.y; end
      default: begin sel_lo = lo.z; sel_hi = hi.z; end
    endcase
    diff     = 33'(sel_hi) - 33'(sel_lo);
    prod_nxt = diff * $signed({1'b0, t_r});
    prod_sh  = prod_r >>> FRAC_BITS;
    sum      = 34'(lo_pipe_r) + prod_sh[33:0];
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 2'd3) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= t;
    end
    if (active_r) begin
      prod_r    <= prod_nxt;
      lo_pipe_r <= sel_lo;
      unique case (cnt_r)
        2'd1:    res_r.x <= sum[31:0];
        2'd2:    res_r.y <= sum[31:0];
        2'd3:    res_r.z <= sum[31:0];
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== rtl/core/wind_profile_interpolator_core.sv =====
// Channel  Dir  Handshake                  Payload
// in_      in   in_valid / in_ready        wpi_in_t: kind, altitude, vel_x/y/z_in
// out_     out  out_valid / out_ready      wpi_out_t: vel_x/y/z_out
//
// A clear and an insert into an empty table complete in the idle state; otherwise
// an insert walks down from the top entry, one shifted layer per cycle.
// A clamped query returns the first or last layer; an interpolated query searches
// for its bracket and then waits on the 17-step fraction divider and the lerp unit.
// Synchronous active-low reset empties the table; the layer memory is not cleared.
// A result waiting on out_ready holds the next query in its final state, but new
// transfers keep being accepted until then.
`include "wind_profile_interpolator_core_macros.svh"

module wind_profile_interpolator_core
  import wpi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wpi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output wpi_out_t out_data
);

  // The sequencer owns the layer memory. Inserts shift layers upward from the top
  // of the table; queries read the first entry, then the last, then scan upward
  // for the bracketing pair before handing off to the divider and the lerp unit.
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_CMP = 9'b000000010,
    S_INS_WR  = 9'b000000100,
    S_Q_LO    = 9'b000001000,
    S_Q_HI    = 9'b000010000,
    S_Q_SCAN  = 9'b000100000,
    S_DIV     = 9'b001000000,
    S_LERP    = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_e;

  state_e              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  wpi_in_t             item_r, item_nxt;
  logic [LAYER_AW-1:0] j_r, j_nxt;
  logic [LAYER_AW-1:0] i_r, i_nxt;
  layer_t              lo_r, lo_nxt;
  layer_t              hi_r, hi_nxt;
  vel_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  wpi_out_t            out_data_r, out_data_nxt;

  ram_req_t            ram_req;
  layer_t              ram_rd;
  layer_t              new_layer;
  logic [CNT_W-1:0]    cnt_m1;
  logic                accept;

  logic                div_start;
  logic [31:0]         div_dividend;
  logic [31:0]         div_divisor;
  logic                div_done;
  logic [T_W-1:0]      div_quot;
  logic                lerp_start;
  logic                lerp_done;
  vel_t                lerp_res;

  wpi_layer_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  wpi_frac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  wpi_lerp_unit u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .lo    (lo_r.vel),
    .hi    (hi_r.vel),
    .t     (div_quot),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_m1   = count_r - 1'b1;

  // The layer being inserted, taken from the captured item.
  assign new_layer = '{altitude: item_r.altitude,
                       vel: '{x: item_r.vel_x_in, y: item_r.vel_y_in, z: item_r.vel_z_in}};

  // The bracket distances; both are positive once a bracket is found.
  assign div_dividend = 32'(item_r.altitude - lo_r.altitude);
  assign div_divisor  = 32'(ram_rd.altitude - lo_r.altitude);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    item_nxt      = item_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    lerp_start    = 1'b0;

    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = j_r;
    ram_req.wr_data = new_layer;
    ram_req.rd_addr = '0;

    // A result is held until the output register is free.
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        // Prefetch the first entry for a query, the top entry for an insert.
        ram_req.rd_addr = (in_data.kind == KIND_QUERY) ? '0 : cnt_m1[LAYER_AW-1:0];
        if (accept) begin
          item_nxt = in_data;
          unique case (in_data.kind)
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            KIND_INSERT: begin
              if (count_r >= CNT_W'(MAX_LAYERS)) begin
                // Full table: the layer is dropped.
              end else if (count_r == '0) begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = '0;
                ram_req.wr_data = '{altitude: in_data.altitude,
                                    vel: '{x: in_data.vel_x_in, y: in_data.vel_y_in,
                                           z: in_data.vel_z_in}};
                count_nxt       = count_r + 1'b1;
              end else begin
                j_nxt     = count_r[LAYER_AW-1:0];
                state_nxt = S_INS_CMP;
              end
            end
            KIND_QUERY: begin
              if (count_r == '0) begin
                res_nxt   = '0;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_Q_LO;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS_CMP: begin
        // ram_rd holds entry j-1. Higher layers move up by one.
        ram_req.wr_en = 1'b1;
        if ($signed(ram_rd.altitude) > $signed(item_r.altitude)) begin
          ram_req.wr_data = ram_rd;
          j_nxt           = j_r - 1'b1;
          if (j_r == LAYER_AW'(1)) begin
            state_nxt = S_INS_WR;
          end else begin
            ram_req.rd_addr = j_r - 1'b1 - 1'b1;
          end
        end else begin
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_INS_WR: begin
        ram_req.wr_en = 1'b1;
        count_nxt     = count_r + 1'b1;
        state_nxt     = S_IDLE;
      end

      S_Q_LO: begin
        if ($signed(item_r.altitude) <= $signed(ram_rd.altitude)) begin
          res_nxt   = ram_rd.vel;
          state_nxt = S_OUT;
        end else begin
          lo_nxt          = ram_rd;
          ram_req.rd_addr = cnt_m1[LAYER_AW-1:0];
          state_nxt       = S_Q_HI;
        end
      end

      S_Q_HI: begin
        // The top check comes before the scan so that equal top altitudes
        // resolve to the last layer.
        if ($signed(item_r.altitude) >= $signed(ram_rd.altitude)) begin
          res_nxt   = ram_rd.vel;
          state_nxt = S_OUT;
        end else begin
          ram_req.rd_addr = LAYER_AW'(1);
          i_nxt           = LAYER_AW'(1);
          state_nxt       = S_Q_SCAN;
        end
      end

      S_Q_SCAN: begin
        // ram_rd holds entry i; lo_r holds entry i-1.
        if ($signed(item_r.altitude) <= $signed(ram_rd.altitude)) begin
          hi_nxt    = ram_rd;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          lo_nxt          = ram_rd;
          i_nxt           = i_r + 1'b1;
          ram_req.rd_addr = i_r + 1'b1;
        end
      end

      S_DIV: begin
        if (div_done) begin
          lerp_start = 1'b1;
          state_nxt  = S_LERP;
        end
      end

      S_LERP: begin
        if (lerp_done) begin
          res_nxt   = lerp_res;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{vel_x_out: res_r.x, vel_y_out: res_r.y, vel_z_out: res_r.z};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WPI_ASSERT_IMPL(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside the divide state")
  `WPI_ASSERT_IMPL(a_lerp_done_in_lerp, lerp_done, state_r == S_LERP, "lerp finished outside the lerp state")
  `WPI_ASSERT_NEXT(a_insert_grows_one, state_r == S_INS_WR, count_r == $past(count_r) + 1'b1, "insert did not add exactly one layer")
  `WPI_ASSERT_IMPL(a_scan_in_table, state_r == S_Q_SCAN, CNT_W'(i_r) < count_r, "bracket scan ran past the last layer")

endmodule

// ===== verif/tb_wind_profile_interpolator_core.sv =====
module tb_wind_profile_interpolator_core;
  import wpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The kind field is two bits wide, but only three codes are defined. The fourth
  // must be ignored by the block, so the stimulus uses it under its own name.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [31:0] ALT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ALT_MAX = 32'sh7FFF_FFFF;

  // These are given in clock cycles. The drain wait covers the slowest query,
  // which is a long bracket search followed by the serial fraction divider.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  wpi_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  wpi_out_t out_data;

  // Items that wait to be offered to the block, and the velocities that queries
  // already accepted by the block must still return.
  wpi_in_t  pending_items[$];
  wpi_out_t expected_vel[$];

  // Shadow of the layer table. It is updated on every accepted clear and insert.
  logic signed [31:0] layer_alt[MAX_LAYERS];
  vel_t               layer_vel[MAX_LAYERS];
  int unsigned        layer_total = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_hold      = 1'b0;
  int unsigned stim_count     = 0;
  int unsigned mismatch_count = 0;

  wind_profile_interpolator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Each component moves from lo toward hi by frac / 65536. The product is exact
  // in 64 bits, and the arithmetic shift rounds toward minus infinity.
  function automatic logic signed [31:0] blend_component(logic signed [31:0] lo,
                                                         logic signed [31:0] hi,
                                                         longint frac);
    longint diff;
    diff = longint'(hi) - longint'(lo);
    return 32'(longint'(lo) + ((diff * frac) >>> 16));
  endfunction

  // This applies one accepted item to the shadow table. A query also pushes the
  // velocity that the block must return for it.
  function automatic void wind_table_step(input wpi_in_t item);
    logic signed [31:0] q_alt;
    wpi_out_t           vel;
    vel_t               lo;
    vel_t               hi;
    int unsigned        pos;
    int unsigned        idx;
    longint             lo_alt;
    longint             gap;
    longint unsigned    num;
    longint unsigned    frac;
    q_alt = item.altitude;
    case (item.kind)
      KIND_CLEAR: begin
        layer_total = 0;
      end
      KIND_INSERT: begin
        // An insert into a full table is dropped. Otherwise the new layer goes
        // after every layer whose altitude is equal or lower.
        if (layer_total < MAX_LAYERS) begin
          pos = 0;
          while (pos < layer_total && layer_alt[pos] <= q_alt) pos++;
          for (idx = layer_total; idx > pos; idx--) begin
            layer_alt[idx] = layer_alt[idx - 1];
            layer_vel[idx] = layer_vel[idx - 1];
          end
          layer_alt[pos] = q_alt;
          layer_vel[pos] = '{item.vel_x_in, item.vel_y_in, item.vel_z_in};
          layer_total++;
        end
      end
      KIND_QUERY: begin
        if (layer_total == 0) begin
          vel = '0;
        end else if (q_alt <= layer_alt[0]) begin
          vel = layer_vel[0];
        end else if (q_alt >= layer_alt[layer_total - 1]) begin
          vel = layer_vel[layer_total - 1];
        end else begin
          // The upper bracket is the first layer at or above the query altitude.
          idx = 1;
          while (idx < layer_total - 1 && q_alt > layer_alt[idx]) idx++;
          lo_alt = layer_alt[idx - 1];
          gap    = longint'(layer_alt[idx]) - lo_alt;
          num    = longint'(longint'(q_alt) - lo_alt) << 16;
          frac   = num / gap;
          if (frac > 65536) frac = 65536;
          lo = layer_vel[idx - 1];
          hi = layer_vel[idx];
          vel.vel_x_out = blend_component(lo.x, hi.x, longint'(frac));
          vel.vel_y_out = blend_component(lo.y, hi.y, longint'(frac));
          vel.vel_z_out = blend_component(lo.z, hi.z, longint'(frac));
        end
        expected_vel = {expected_vel, vel};
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Driver. Once valid is raised, it stays high with the same payload until the
  // transfer happens. The next item goes out at once or after a random gap.
  always @(posedge clk) begin
    logic    next_valid;
    wpi_in_t next_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_data  = in_data;
      if (in_valid && in_ready) begin
        wind_table_step(in_data);
        next_valid = 1'b0;
      end
      if (!next_valid && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_data  = pending_items.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // Monitor. Every result transfer is checked against the oldest waiting
  // expectation. Ready is then drawn again for the next cycle.
  always @(posedge clk) begin
    wpi_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_vel.size() == 0) begin
        $display("%0t: unexpected result, got %h %h %h", $time,
                 out_data.vel_x_out, out_data.vel_y_out, out_data.vel_z_out);
        mismatch_count++;
      end else begin
        want = expected_vel.pop_front();
        check_field("vel_x_out", want.vel_x_out, out_data.vel_x_out);
        check_field("vel_y_out", want.vel_y_out, out_data.vel_y_out);
        check_field("vel_z_out", want.vel_z_out, out_data.vel_z_out);
      end
    end
    out_ready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_item(logic [1:0] kind, logic signed [31:0] alt,
                           logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz);
    wpi_in_t item;
    item.kind     = kind;
    item.altitude = alt;
    item.vel_x_in = vx;
    item.vel_y_in = vy;
    item.vel_z_in = vz;
    pending_items = {pending_items, item};
    if (kind != KIND_UNUSED) stim_count++;
  endtask

  // A well-formed profile mostly has a clear, a handful of layers, then queries.
  // The layer spread is sometimes tight, which gives many equal altitudes, and
  // sometimes the whole altitude range. Now and then a profile asks for more
  // layers than the table holds, so that the extra inserts get dropped.
  task automatic gen_sequence();
    logic signed [31:0] known[$];
    logic signed [31:0] base;
    logic signed [31:0] alt;
    int unsigned        span;
    int unsigned        n_layers;
    int unsigned        n_queries;
    int unsigned        pick;
    base = $urandom();
    case ($urandom_range(3))
      0:       span = 16;
      1:       span = 4096;
      2:       span = 1 << 20;
      default: span = 32'hFFFF_FFFF;
    endcase
    if ($urandom_range(9) != 0) push_item(KIND_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
    n_layers = ($urandom_range(9) == 0) ? MAX_LAYERS + 1 + $urandom_range(1)
                                        : $urandom_range(MAX_LAYERS);
    for (int i = 0; i < n_layers; i++) begin
      if (known.size() != 0 && $urandom_range(4) == 0) alt = known[$urandom_range(known.size() - 1)];
      else alt = base + $urandom_range(span);
      known = {known, alt};
      push_item(KIND_INSERT, alt, $urandom(), $urandom(), $urandom());
    end
    n_queries = 1 + $urandom_range(5);
    for (int i = 0; i < n_queries; i++) begin
      pick = $urandom_range(9);
      if (pick < 5) alt = base + $urandom_range(span);
      else if (pick < 7 && known.size() != 0)
        alt = known[$urandom_range(known.size() - 1)] + $urandom_range(2) - 1;
      else if (pick == 8) alt = base - 32'd1 - $urandom_range(15);
      else if (pick == 9) alt = $urandom_range(1) ? ALT_MAX : ALT_MIN;
      else alt = $urandom();
      push_item(KIND_QUERY, alt, $urandom(), $urandom(), $urandom());
    end
  endtask

  // Noise has every field random, and that includes the unused kind code.
  task automatic gen_noise();
    for (int i = 0; i < 1 + $urandom_range(3); i++)
      push_item(2'($urandom_range(3)), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // The sender stays quiet until every queued item has been taken and every
  // expected result has come back.
  task automatic drain_all();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_vel.size() != 0);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned stall_pct,
                           int unsigned count, int unsigned hold);
    int unsigned target;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target = stim_count + count;
    while (stim_count < target) begin
      if ($urandom_range(7) == 0) gen_noise();
      else gen_sequence();
    end
    // While the receiver is held off, the sender keeps offering items. The block
    // then has to fill up and push back on its input.
    if (hold != 0) begin
      fork
        begin
          recv_hold = 1'b1;
          repeat (hold) @(negedge clk);
          recv_hold = 1'b0;
        end
      join_none
    end
    drain_all();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. It runs a query on the empty table, sends the unused kind,
    // spans the whole altitude range with extreme velocities, and checks both
    // clamps. It then covers equal altitudes, a full table that drops an insert,
    // a clear, and a table that holds a single layer.
    push_item(KIND_QUERY, 32'sd0, ALT_MAX, ALT_MIN, ALT_MAX);
    push_item(KIND_UNUSED, ALT_MAX, ALT_MAX, ALT_MAX, ALT_MAX);
    push_item(KIND_INSERT, ALT_MAX, ALT_MAX, ALT_MAX, ALT_MAX);
    push_item(KIND_INSERT, ALT_MIN, ALT_MIN, ALT_MIN, ALT_MIN);
    push_item(KIND_QUERY, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, ALT_MIN, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, ALT_MAX, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_INSERT, 32'sd0, 32'sh0001_0000, -32'sh0002_0000, 32'sd0);
    push_item(KIND_INSERT, 32'sd0, -32'sh0001_0000, 32'sh0003_8000, 32'sd7);
    push_item(KIND_QUERY, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, -32'sd1, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_INSERT, 32'sd16, 32'sh0010_0000, 32'sh0000_0001, -32'sd1);
    push_item(KIND_INSERT, 32'sd32, -32'sh0010_0000, 32'sh7FFF_0000, 32'sd3);
    push_item(KIND_INSERT, -32'sd16, 32'sh0000_8000, -32'sd5, 32'sh0100_0000);
    push_item(KIND_INSERT, 32'sd48, 32'sh0003_0000, 32'sd9, -32'sh0100_0000);
    push_item(KIND_INSERT, 32'sd100, ALT_MAX, ALT_MAX, ALT_MAX);
    push_item(KIND_QUERY, 32'sd40, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, 32'sd20, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_CLEAR, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, 32'sd5, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_INSERT, 32'sd160, 32'sh0004_0000, -32'sh0004_0000, 32'sd1);
    push_item(KIND_QUERY, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, 32'sd160, 32'sd0, 32'sd0, 32'sd0);
    push_item(KIND_QUERY, 32'sd400, 32'sd0, 32'sd0, 32'sd0);
    drain_all();

    // Random part. The first phase has no idling apart from one long hold-off
    // on the result side. The later phases add gaps on the input side, stalls
    // on the result side, and then light idling on both.
    run_phase(0, 0, 150, HOLD_CYCLES);
    run_phase(47, 0, 160, 0);
    run_phase(0, 47, 160, 0);
    run_phase(7, 7, 180, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_vel.size() == 0) begin
      $display("[wind_profile_interpolator_core] OK");
    end else begin
      $display("[wind_profile_interpolator_core] ERROR");
    end
    $finish;
  end

  // Watchdog. A correct run needs well under a tenth of this time.
  initial begin
    #1_000_000;
    $display("[wind_profile_interpolator_core] ERROR");
    $finish;
  end

endmodule
